/* src/scalar_kalman_filter_top_assert.svh */
// ----------------------------------------------------------------------------
// scalar kalman filter assertion macros
// shared concurrent assertion forms, clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_TOP_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define SKF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/skf_pkg.sv */
// ----------------------------------------------------------------------------
// skf_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

  // default fraction bits of variance, noise and gain
  localparam int unsigned FRAC_BITS_DEF = 16;

  // fixed field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned EST_W    = 18;
  localparam int unsigned GAIN_W   = 17;
  localparam int unsigned NOISE_W  = 24;
  localparam int unsigned VAR_W    = 25;
  localparam int unsigned S_DATA_W = 16;
  localparam int unsigned M_DATA_W = 40;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 1'b1;

  // estimate after reset: 22 degrees in 1/256 degree units
  localparam logic [EST_W-1:0] EST_RESET = 18'd5632;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture sample, predicted variance
    logic prep;      // denominator and divider setup
    logic div_step;  // one restoring division step
    logic mul_x;     // gain times estimate error
    logic upd_x;     // estimate update
    logic mul_p;     // (1 - gain) times variance
    logic upd_p;     // variance update
    logic out_load;  // load result register
  } skf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;  // result register can take a new result
  } skf_sts_t;

endpackage

`default_nettype wire

/* src/skf_ctrl.sv */
// ----------------------------------------------------------------------------
// skf_ctrl
// step sequencer: accept, divide, two multiply/update pairs, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

`include "scalar_kalman_filter_top_assert.svh"

module skf_ctrl #(
  parameter int unsigned FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               s_valid_i,
  output logic              s_ready_o,
  input  skf_pkg::skf_sts_t sts_i,
  output skf_pkg::skf_cmd_t cmd_o
);

  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_MULX   = 3'd3;
  localparam logic [2:0] ST_UPDX   = 3'd4;
  localparam logic [2:0] ST_MULP   = 3'd5;
  localparam logic [2:0] ST_UPDP   = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign s_ready_o = (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_MULX;
        end
      end
      ST_MULX: begin
        cmd_o.mul_x = 1'b1;
        state_d     = ST_UPDX;
      end
      ST_UPDX: begin
        cmd_o.upd_x = 1'b1;
        state_d     = ST_MULP;
      end
      ST_MULP: begin
        cmd_o.mul_p = 1'b1;
        state_d     = ST_UPDP;
      end
      ST_UPDP: begin
        cmd_o.upd_p = 1'b1;
        state_d     = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // result never overwrites one that is still waiting
  `SKF_ASSERT_IMP(a_load_free, cmd_o.out_load, sts_i.out_free, "result overwritten")
  // an accepted sample starts the divider setup next
  `SKF_ASSERT_NXT(a_accept_prep, s_valid_i && s_ready_o, state_q == ST_PREP, "no prep")
  // divider step count stays within the quotient width
  `SKF_ASSERT_IMP(a_div_cnt, state_q == ST_DIV, cnt_q <= CNT_LAST, "div count overrun")

endmodule

`default_nettype wire

/* src/skf_datapath.sv */
// ----------------------------------------------------------------------------
// skf_datapath
// noise registers, filter state, restoring divider, shared multiplier, result
// ----------------------------------------------------------------------------
`default_nettype none

`include "scalar_kalman_filter_top_assert.svh"

module skf_datapath #(
  parameter int unsigned FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire [skf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire [skf_pkg::NOISE_W-1:0]          cfg_wdata_i,
  input  wire [skf_pkg::SAMPLE_W-1:0]         sample_i,
  input  skf_pkg::skf_cmd_t                   cmd_i,
  output skf_pkg::skf_sts_t                   sts_o,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [skf_pkg::EST_W-1:0]           estimate_o,
  output logic [skf_pkg::GAIN_W-1:0]          gain_now_o
);

  localparam int unsigned EST_W   = skf_pkg::EST_W;
  localparam int unsigned VAR_W   = skf_pkg::VAR_W;
  localparam int unsigned NOISE_W = skf_pkg::NOISE_W;
  localparam int unsigned GAIN_W  = skf_pkg::GAIN_W;
  localparam int unsigned K_W     = FRAC_BITS + 1;
  localparam int unsigned PROD_W  = K_W + VAR_W;
  localparam int unsigned REM_W   = VAR_W + 2;
  localparam logic [K_W-1:0] ONE  = K_W'(1) << FRAC_BITS;
  localparam int unsigned NOISE_RST_I = ((1 << FRAC_BITS) + 5) / 10;
  localparam logic [NOISE_W-1:0] NOISE_RST = NOISE_W'(NOISE_RST_I);

  logic [NOISE_W-1:0] q_q, r_q;
  logic [EST_W-1:0]   x_q, x_d;
  logic [VAR_W-1:0]   var_q;
  logic [EST_W-1:0]   tgt_q;
  logic [VAR_W-1:0]   p_q;
  logic [VAR_W:0]     den_q;
  logic               den_zero_q;
  logic [REM_W-1:0]   rem_q;
  logic [K_W-1:0]     k_q;
  logic [PROD_W-1:0]  prod_q;
  logic               out_valid_q;
  logic [EST_W-1:0]   est_out_q;
  logic [GAIN_W-1:0]  gain_out_q;

  logic [VAR_W:0]     p_sum;
  logic [VAR_W-1:0]   p_sat;
  logic [VAR_W:0]     den_sum;
  logic               rem_ge;
  logic [REM_W-1:0]   rem_diff;
  logic [K_W-1:0]     k_eff;
  logic               x_up;
  logic [EST_W-1:0]   dmag;
  logic [K_W-1:0]     mul_a;
  logic [VAR_W-1:0]   mul_b;
  logic [PROD_W-1:0]  prod_rnd;
  logic [GAIN_W-1:0]  gain_q16;

  // noise registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= NOISE_RST;
      r_q <= NOISE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        skf_pkg::REG_PROCESS_NOISE: q_q <= cfg_wdata_i;
        skf_pkg::REG_MEASURE_NOISE: r_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // predicted variance, saturating at full scale
  assign p_sum   = {1'b0, var_q} + {2'b0, q_q};
  assign p_sat   = p_sum[VAR_W] ? '1 : p_sum[VAR_W-1:0];
  assign den_sum = {1'b0, p_q} + {2'b0, r_q};

  // restoring division step, remainder kept pre-shifted
  assign rem_ge   = (rem_q >= {1'b0, den_q});
  assign rem_diff = rem_ge ? (rem_q - {1'b0, den_q}) : rem_q;

  // zero denominator gives zero gain
  assign k_eff = den_zero_q ? '0 : k_q;

  // estimate error magnitude and direction
  assign x_up = (tgt_q >= x_q);
  assign dmag = x_up ? (tgt_q - x_q) : (x_q - tgt_q);

  // shared multiplier operands
  assign mul_a = cmd_i.mul_p ? (ONE - k_eff) : k_eff;
  assign mul_b = cmd_i.mul_p ? p_q : {{(VAR_W-EST_W){1'b0}}, dmag};

  // downward step rounds toward minus infinity
  assign prod_rnd = prod_q + PROD_W'(ONE - 1'b1);

  always_comb begin
    if (x_up) begin
      x_d = x_q + EST_W'(prod_q >> FRAC_BITS);
    end else begin
      x_d = x_q - EST_W'(prod_rnd >> FRAC_BITS);
    end
  end

  // gain in 16 fraction bits
  generate
    if (FRAC_BITS >= 16) begin : g_gain_trunc
      assign gain_q16 = GAIN_W'(k_eff >> (FRAC_BITS - 16));
    end else begin : g_gain_shift
      assign gain_q16 = GAIN_W'({k_eff, {(16 - FRAC_BITS){1'b0}}});
    end
  endgenerate

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= skf_pkg::EST_RESET;
      var_q <= VAR_W'(ONE);
    end else begin
      if (cmd_i.upd_x) begin
        x_q <= x_d;
      end
      if (cmd_i.upd_p) begin
        var_q <= VAR_W'(prod_q >> FRAC_BITS);
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tgt_q <= {sample_i, 6'b0};
      p_q   <= p_sat;
    end
    if (cmd_i.prep) begin
      den_q      <= den_sum;
      den_zero_q <= (den_sum == '0);
      rem_q      <= REM_W'(p_q);
      k_q        <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_diff << 1;
      k_q   <= {k_q[K_W-2:0], rem_ge};
    end
    if (cmd_i.mul_x || cmd_i.mul_p) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      est_out_q  <= x_q;
      gain_out_q <= gain_q16;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign estimate_o     = est_out_q;
  assign gain_now_o     = gain_out_q;

  // gain never exceeds one when it is used
  `SKF_ASSERT_IMP(a_gain_max, cmd_i.mul_x, k_eff <= ONE, "gain above one")
  // updated estimate lies between old estimate and target
  `SKF_ASSERT_NXT(a_x_between, cmd_i.upd_x,
    ((tgt_q >= $past(x_q)) ? (x_q >= $past(x_q) && x_q <= tgt_q)
                           : (x_q <= $past(x_q) && x_q >= tgt_q)),
    "estimate left its interval")
  // loading a result shows it next cycle
  `SKF_ASSERT_NXT(a_out_shown, cmd_i.out_load, out_valid_q, "result not shown")

endmodule

`default_nettype wire

/* src/scalar_kalman_filter_top.sv */
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top
// one-dimensional kalman filter for a temperature sample stream
// ----------------------------------------------------------------------------
// usage:
//   slave stream carries one temperature sample (quarter degrees) per
//   transfer; master stream returns one result per sample: the new estimate
//   (1/256 degree) and the gain used (Q1.16).
//   process and measurement noise are written through cfg_we_i / cfg_idx_i /
//   cfg_wdata_i while the filter is idle; a write takes effect at once.
// timing:
//   a sample is taken only in the idle state, one at a time. after the
//   sample transfer the sequencer runs prep, the divider steps, the two
//   multiply/update pairs and a finish state that loads the result
//   register, then returns to idle for the next sample. the gain divider
//   is a restoring divider producing one quotient bit per cycle.
// reset:
//   estimate returns to 22 degrees, variance to 1.0, both noise registers to
//   0.1; no result is pending.
// stall:
//   a result waits in the output register while m_axis_tready is low; the
//   next sample may already be taken and processed, and its result is held
//   back until the waiting one has been transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter_top #(
  parameter int unsigned FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // configuration write port
  input  wire                               cfg_we_i,
  input  wire [skf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire [skf_pkg::NOISE_W-1:0]        cfg_wdata_i,
  // sample stream
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire [skf_pkg::S_DATA_W-1:0]       s_axis_tdata,  // [11:0] sample_quarter_deg
  // result stream
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [skf_pkg::M_DATA_W-1:0]      m_axis_tdata   // [17:0] estimate, [34:18] gain_now
);

  skf_pkg::skf_cmd_t              cmd;
  skf_pkg::skf_sts_t              sts;
  logic [skf_pkg::EST_W-1:0]      estimate;
  logic [skf_pkg::GAIN_W-1:0]     gain_now;

  // sequencer
  skf_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // arithmetic and state
  skf_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (s_axis_tdata[skf_pkg::SAMPLE_W-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .estimate_o  (estimate),
    .gain_now_o  (gain_now)
  );

  // result packing, zero filled to whole bytes
  assign m_axis_tdata = {
    {(skf_pkg::M_DATA_W - skf_pkg::GAIN_W - skf_pkg::EST_W){1'b0}},
    gain_now,
    estimate
  };

endmodule

`default_nettype wire
